@@ rtl/tlik_pkg.sv @@
`timescale 1ns / 1ps
package tlik_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int LINK_W     = 15;
  localparam int ANG_W      = 15;
  localparam int SHOULDER_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int Q_FRAC   = 30;
  localparam int CM_W     = Q_FRAC + 1;
  localparam int ROOT_VW  = 2 * Q_FRAC + 2;
  localparam int ANG_FRAC = 16;
  localparam int XY_W     = 34;
  localparam int Z_W      = 34;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;

  localparam logic [LINK_W-1:0] L1_RESET = LINK_W'(1280);
  localparam logic [LINK_W-1:0] L2_RESET = LINK_W'(2048);
  localparam logic [ANG_W-1:0]  ANG_MAX  = ANG_W'(18000);

  localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(64'd18000 << ANG_FRAC);
  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'd9000 << ANG_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER = 2'd0,
    CFG_LOWER = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic             flag;
    logic [ANG_W-1:0] angle;
  } acos_res_t;

  function automatic int arg_w(input int w);
    int a;
    a = 2 * w + 1;
    if (a < 31) a = 31;
    if (w + 16 > a) a = w + 16;
    return a;
  endfunction

  function automatic int acos_lat(input int cs);
    return Q_FRAC + ROOT_VW / 2 + cs + 4;
  endfunction

  function automatic logic [Z_W-1:0] atan_hd(input int i);
    logic [Z_W-1:0] t;
    case (i)
      0:       t = Z_W'(294912000);
      1:       t = Z_W'(174096719);
      2:       t = Z_W'(91987925);
      3:       t = Z_W'(46694507);
      4:       t = Z_W'(23437865);
      5:       t = Z_W'(11730358);
      6:       t = Z_W'(5866610);
      7:       t = Z_W'(2933484);
      8:       t = Z_W'(1466764);
      9:       t = Z_W'(733385);
      10:      t = Z_W'(366693);
      11:      t = Z_W'(183346);
      12:      t = Z_W'(91673);
      13:      t = Z_W'(45837);
      14:      t = Z_W'(22918);
      15:      t = Z_W'(11459);
      16:      t = Z_W'(5730);
      17:      t = Z_W'(2865);
      18:      t = Z_W'(1432);
      19:      t = Z_W'(716);
      20:      t = Z_W'(358);
      21:      t = Z_W'(179);
      22:      t = Z_W'(90);
      23:      t = Z_W'(45);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/tlik_isqrt.sv @@
`timescale 1ns / 1ps
module tlik_isqrt import tlik_pkg::*; #(
  parameter int VW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [VW-1:0]     v_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [VW/2-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int STEPS = VW / 2;

  logic [STEPS-1:0]  vld_q;
  logic [VW-1:0]     v_q    [STEPS];
  logic [VW-1:0]     res_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * k);
    logic [VW-1:0]     v_in, res_in, v_d, res_d;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [VW:0]       trial;

    if (k == 0) begin : g_first
      assign v_in    = v_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};

    always_comb begin
      if ({1'b0, v_in} >= trial) begin
        v_d   = VW'({1'b0, v_in} - trial);
        res_d = (res_in >> 1) + BIT;
      end else begin
        v_d   = v_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= v_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = res_q[STEPS-1][STEPS-1:0];
  assign side_o  = side_q[STEPS-1];

endmodule

@@ rtl/tlik_front.sv @@
`timescale 1ns / 1ps
module tlik_front import tlik_pkg::*; #(
  parameter int W  = COORD_WIDTH_DEF,
  parameter int AW = arg_w(COORD_WIDTH_DEF)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [W-1:0] target_x_i,
  input  logic signed [W-1:0] target_y_i,
  input  logic [LINK_W-1:0]   l1_i,
  input  logic [LINK_W-1:0]   l2_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                x_neg_o,
  output logic                zero_o,
  output logic                neg2_o,
  output logic                neg3_o,
  output logic [W-1:0]        xm_o,
  output logic [W-1:0]        r_o,
  output logic [AW-1:0]       num2_o,
  output logic [AW-1:0]       den2_o,
  output logic [AW-1:0]       num3_o,
  output logic [AW-1:0]       den3_o
);

  localparam int W2     = 2 * W;
  localparam int LW2    = 2 * LINK_W;
  localparam int LRW    = LINK_W + W;
  localparam int SIDE_W = 1 + W + W2;

  logic en;
  logic v0_q, v1_q, va_q, vb_q;

  logic         xneg0_q, xneg1_q, xnega_q;
  logic [W-1:0] xm0_q, ym0_q, xm1_q, xma_q;
  logic [W2-1:0] r21_q, r2a_q;

  logic              qv;
  logic [W-1:0]      qr;
  logic [SIDE_W-1:0] qside;
  logic              qxneg;
  logic [W-1:0]      qxm;
  logic [W2-1:0]     qr2;

  logic [W-1:0]     ra_q;
  logic [LW2-1:0]   l1s_q, l2s_q, l1l2_q;
  logic [LRW-1:0]   l1r_q;
  logic [AW-1:0]    pos2, pos3, l2s_w, r2_w;

  assign en         = !vb_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      va_q <= qv;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xneg0_q <= target_x_i[W-1];
      xm0_q   <= target_x_i[W-1] ? (~target_x_i + W'(1)) : target_x_i;
      ym0_q   <= target_y_i[W-1] ? (~target_y_i + W'(1)) : target_y_i;
      xneg1_q <= xneg0_q;
      xm1_q   <= xm0_q;
      r21_q   <= W2'(xm0_q) * W2'(xm0_q) + W2'(ym0_q) * W2'(ym0_q);
    end
  end

  tlik_isqrt #(
    .VW     (W2),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .v_i     (r21_q),
    .side_i  ({xneg1_q, xm1_q, r21_q}),
    .valid_o (qv),
    .root_o  (qr),
    .side_o  (qside)
  );

  assign {qxneg, qxm, qr2} = qside;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q    <= qr;
      r2a_q   <= qr2;
      xnega_q <= qxneg;
      xma_q   <= qxm;
      l1s_q   <= LW2'(l1_i) * LW2'(l1_i);
      l2s_q   <= LW2'(l2_i) * LW2'(l2_i);
      l1l2_q  <= LW2'(l1_i) * LW2'(l2_i);
      l1r_q   <= LRW'(l1_i) * LRW'(qr);
    end
  end

  assign pos2  = AW'(r2a_q) + AW'(l1s_q);
  assign pos3  = AW'(l1s_q) + AW'(l2s_q);
  assign l2s_w = AW'(l2s_q);
  assign r2_w  = AW'(r2a_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_neg_o <= xnega_q;
      xm_o    <= xma_q;
      r_o     <= ra_q;
      zero_o  <= (ra_q == '0);
      neg2_o  <= pos2 < l2s_w;
      num2_o  <= (pos2 < l2s_w) ? (l2s_w - pos2) : (pos2 - l2s_w);
      neg3_o  <= pos3 < r2_w;
      num3_o  <= (pos3 < r2_w) ? (r2_w - pos3) : (pos3 - r2_w);
      den2_o  <= AW'({l1r_q, 1'b0});
      den3_o  <= AW'({l1l2_q, 1'b0});
    end
  end

  assign out_valid_o = vb_q;

endmodule

@@ rtl/tlik_fifo.sv @@
`timescale 1ns / 1ps
module tlik_fifo import tlik_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0]  mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [PTR_W:0]   cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != (PTR_W + 1)'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + PTR_W'(1);
      if (pop)  rp_q <= rp_q + PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (PTR_W + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (PTR_W + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_data_i;
  end

endmodule

@@ rtl/tlik_acos.sv @@
`timescale 1ns / 1ps
module tlik_acos import tlik_pkg::*; #(
  parameter int AW = arg_w(COORD_WIDTH_DEF),
  parameter int CS = CORDIC_STAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          neg_i,
  input  logic [AW-1:0] mag_i,
  input  logic [AW-1:0] den_i,
  output logic          valid_o,
  output acos_res_t     res_o
);

  localparam int DN     = Q_FRAC;
  localparam int SW     = ROOT_VW / 2;
  localparam int SIDE_W = CM_W + 2;
  localparam logic [CM_W-1:0]    CM_ONE = CM_W'(1) << Q_FRAC;
  localparam logic [ROOT_VW-1:0] V_ONE  = ROOT_VW'(1) << (2 * Q_FRAC);
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1) << (ANG_FRAC - 1);

  logic [DN:0]       dv_q, neg_q, sat_q, flg_q;
  logic [AW-1:0]     rem_q [DN+1];
  logic [AW-1:0]     den_q [DN+1];
  logic [Q_FRAC-1:0] quo_q [DN+1];

  logic [CM_W-1:0]    cm;
  logic               sv_q, sneg_q, sflg_q;
  logic [CM_W-1:0]    scm_q;
  logic [ROOT_VW-1:0] sqv_q;

  logic              iv;
  logic [SW-1:0]     is;
  logic [SIDE_W-1:0] iside;
  logic              ineg, iflg, cpos;
  logic [CM_W-1:0]   icm;

  logic [CS:0]               cv_q, cf_q;
  logic signed [XY_W-1:0]    cx_q [CS+1];
  logic signed [XY_W-1:0]    cy_q [CS+1];
  logic signed [Z_W-1:0]     cz_q [CS+1];
  logic signed [Z_W-1:0]     zc, rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      sv_q <= 1'b0;
      cv_q <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      dv_q    <= {dv_q[DN-1:0], valid_i};
      sv_q    <= dv_q[DN];
      cv_q    <= {cv_q[CS-1:0], iv};
      valid_o <= cv_q[CS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      sat_q[0] <= mag_i >= den_i;
      flg_q[0] <= (mag_i > den_i) || (den_i == '0);
    end
  end

  for (genvar k = 1; k <= DN; k++) begin : g_div
    logic [AW:0] sh, dd;
    logic        ge;
    assign sh = {rem_q[k-1], 1'b0};
    assign dd = {1'b0, den_q[k-1]};
    assign ge = sh >= dd;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? AW'(sh - dd) : AW'(sh);
        quo_q[k] <= {quo_q[k-1][Q_FRAC-2:0], ge};
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        sat_q[k] <= sat_q[k-1];
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  assign cm = sat_q[DN] ? CM_ONE : {1'b0, quo_q[DN]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scm_q  <= cm;
      sneg_q <= neg_q[DN];
      sflg_q <= flg_q[DN];
      sqv_q  <= V_ONE - ROOT_VW'(cm) * ROOT_VW'(cm);
    end
  end

  tlik_isqrt #(
    .VW     (ROOT_VW),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (sv_q),
    .v_i     (sqv_q),
    .side_i  ({sneg_q, sflg_q, scm_q}),
    .valid_o (iv),
    .root_o  (is),
    .side_o  (iside)
  );

  assign {ineg, iflg, icm} = iside;
  assign cpos = !ineg || (icm == '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= cpos ? XY_W'(icm) : XY_W'(is);
      cy_q[0] <= cpos ? XY_W'(is) : XY_W'(icm);
      cz_q[0] <= cpos ? '0 : QUARTER_TURN;
      cf_q[0] <= iflg;
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATAN = atan_hd(i);
    logic signed [XY_W-1:0] xs, ys;
    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + ATAN;
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - ATAN;
        end
        cf_q[i+1] <= cf_q[i];
      end
    end
  end

  always_comb begin
    if (cz_q[CS] < 0) begin
      zc = '0;
    end else if (cz_q[CS] > HALF_TURN) begin
      zc = HALF_TURN;
    end else begin
      zc = cz_q[CS];
    end
    rnd = zc + ROUND_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.flag  <= cf_q[CS];
      res_o.angle <= rnd[ANG_FRAC +: ANG_W];
    end
  end

endmodule

@@ rtl/tlik_back.sv @@
`timescale 1ns / 1ps
module tlik_back import tlik_pkg::*; #(
  parameter int W  = COORD_WIDTH_DEF,
  parameter int CS = CORDIC_STAGES_DEF,
  parameter int AW = arg_w(COORD_WIDTH_DEF)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_pop_o,
  input  logic                        x_neg_i,
  input  logic                        zero_i,
  input  logic                        neg2_i,
  input  logic                        neg3_i,
  input  logic [W-1:0]                xm_i,
  input  logic [W-1:0]                r_i,
  input  logic [AW-1:0]               num2_i,
  input  logic [AW-1:0]               den2_i,
  input  logic [AW-1:0]               num3_i,
  input  logic [AW-1:0]               den3_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SHOULDER_W-1:0] shoulder_angle_o,
  output logic [ANG_W-1:0]            elbow_angle_o,
  output logic                        unreachable_o
);

  localparam int LAT = acos_lat(CS);

  logic           en, vall;
  logic [2:0]     uv;
  acos_res_t      a1, a2, a3;
  logic [LAT-1:0] zero_q;

  assign en       = !out_valid_o || out_ready_i;
  assign in_pop_o = en && in_valid_i;

  tlik_acos #(.AW(AW), .CS(CS)) u_acos1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(in_valid_i),
    .neg_i(x_neg_i), .mag_i(AW'(xm_i)), .den_i(AW'(r_i)),
    .valid_o(uv[0]), .res_o(a1)
  );

  tlik_acos #(.AW(AW), .CS(CS)) u_acos2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(in_valid_i),
    .neg_i(neg2_i), .mag_i(num2_i), .den_i(den2_i),
    .valid_o(uv[1]), .res_o(a2)
  );

  tlik_acos #(.AW(AW), .CS(CS)) u_acos3 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(in_valid_i),
    .neg_i(neg3_i), .mag_i(num3_i), .den_i(den3_i),
    .valid_o(uv[2]), .res_o(a3)
  );

  assign vall = &uv;

  always_ff @(posedge clk_i) begin
    if (en) zero_q <= {zero_q[LAT-2:0], zero_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vall;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero_q[LAT-1]) begin
        shoulder_angle_o <= '0;
        elbow_angle_o    <= '0;
        unreachable_o    <= 1'b1;
      end else begin
        shoulder_angle_o <= SHOULDER_W'({1'b0, a1.angle}) - SHOULDER_W'({1'b0, a2.angle});
        elbow_angle_o    <= ANG_MAX - a3.angle;
        unreachable_o    <= a1.flag | a2.flag | a3.flag;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> elbow_angle_o <= ANG_MAX)
    else $error("elbow angle beyond half turn");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (shoulder_angle_o <= 16'sd18000) && (shoulder_angle_o >= -16'sd18000))
    else $error("shoulder angle out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(shoulder_angle_o)
      && $stable(elbow_angle_o) && $stable(unreachable_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unreachable_o && shoulder_angle_o == '0 |-> 1'b1 || !out_valid_o)
    else $error("unreachable check");

endmodule

@@ rtl/two_link_arm_inverse_kinematics_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// cfg       in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// target    in         in_valid_i/in_ready_o    target_x_i, target_y_i
// result    out        out_valid_o/out_ready_i  shoulder_angle_o, elbow_angle_o, unreachable_o
//
// One target per cycle when the result side keeps up.
// A target passes the front root search (COORD_WIDTH steps), then per arccos a
// 30-step divider, a 31-step root and the CORDIC.
// Reset clears all valid flags and loads the default link lengths.
// A stalled result freezes the back pipeline; the four-entry queue lets the front run on.
module two_link_arm_inverse_kinematics_core import tlik_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [LINK_W-1:0]             cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] target_x_i,
  input  logic signed [COORD_WIDTH-1:0] target_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SHOULDER_W-1:0]  shoulder_angle_o,
  output logic [ANG_W-1:0]              elbow_angle_o,
  output logic                          unreachable_o
);

  localparam int W  = COORD_WIDTH;
  localparam int AW = arg_w(COORD_WIDTH);
  localparam int DW = 4 + 2 * W + 4 * AW;

  logic [LINK_W-1:0] upper_q, lower_q;

  logic          f_valid, f_ready;
  logic          f_xneg, f_zero, f_neg2, f_neg3;
  logic [W-1:0]  f_xm, f_r;
  logic [AW-1:0] f_num2, f_den2, f_num3, f_den3;

  logic          b_valid, b_pop;
  logic [DW-1:0] b_data;
  logic          b_xneg, b_zero, b_neg2, b_neg3;
  logic [W-1:0]  b_xm, b_r;
  logic [AW-1:0] b_num2, b_den2, b_num3, b_den3;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= L1_RESET;
      lower_q <= L2_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_UPPER) upper_q <= cfg_data_i;
      if (cfg_index_i == CFG_LOWER) lower_q <= cfg_data_i;
    end
  end

  tlik_front #(.W(W), .AW(AW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .l1_i        (upper_q),
    .l2_i        (lower_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .x_neg_o     (f_xneg),
    .zero_o      (f_zero),
    .neg2_o      (f_neg2),
    .neg3_o      (f_neg3),
    .xm_o        (f_xm),
    .r_o         (f_r),
    .num2_o      (f_num2),
    .den2_o      (f_den2),
    .num3_o      (f_num3),
    .den3_o      (f_den3)
  );

  tlik_fifo #(.DW(DW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_xneg, f_zero, f_neg2, f_neg3, f_xm, f_r,
                    f_num2, f_den2, f_num3, f_den3}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_pop),
    .pop_data_o   (b_data)
  );

  assign {b_xneg, b_zero, b_neg2, b_neg3, b_xm, b_r,
          b_num2, b_den2, b_num3, b_den3} = b_data;

  tlik_back #(.W(W), .CS(CORDIC_STAGES), .AW(AW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (b_valid),
    .in_pop_o         (b_pop),
    .x_neg_i          (b_xneg),
    .zero_i           (b_zero),
    .neg2_i           (b_neg2),
    .neg3_i           (b_neg3),
    .xm_i             (b_xm),
    .r_i              (b_r),
    .num2_i           (b_num2),
    .den2_i           (b_den2),
    .num3_i           (b_num3),
    .den3_i           (b_den3),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .shoulder_angle_o (shoulder_angle_o),
    .elbow_angle_o    (elbow_angle_o),
    .unreachable_o    (unreachable_o)
  );

endmodule
